// File: hdl/bia_pkg.sv
package bia_pkg;

  // Map geometry
  localparam int MAX_ELEMENTS = 1024;
  localparam int WORD_BITS    = 32;
  localparam int MAP_WORDS    = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int WIDX_W       = $clog2(MAP_WORDS);
  localparam int OFF_W        = WIDX_W + BIT_W;
  localparam int CNT_W        = OFF_W + 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int ELEM_W   = 16;
  localparam int ECOUNT_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd0;
  localparam logic [OP_W-1:0] OP_OCCUPY   = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ELEMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd1;

  localparam logic [ELEM_W-1:0]   FIRST_RESET = 16'd0;
  localparam logic [ECOUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] element;
  } in_t;

  typedef struct packed {
    logic              success;
    logic [ELEM_W-1:0] granted_element;
  } out_t;

  // Map memory access from the sequencer
  typedef struct packed {
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } map_req_t;

  // Bits of word w whose offset lies below limit
  function automatic logic [WORD_BITS-1:0] below_mask(logic [WIDX_W-1:0] w,
                                                      logic [CNT_W-1:0] limit);
    logic [WIDX_W:0]      lw;
    logic [WORD_BITS-1:0] m;
    lw = limit[CNT_W-1:BIT_W];
    if (lw > {1'b0, w}) begin
      m = '1;
    end else if (lw == {1'b0, w}) begin
      m = ({{(WORD_BITS-1){1'b0}}, 1'b1} << limit[BIT_W-1:0]) - 1'b1;
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

// File: hdl/bia_map_ram.sv
module bia_map_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bia_pkg::map_req_t             req,
  output logic [bia_pkg::WORD_BITS-1:0] rd_word
);
  import bia_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rd_word_r;
  logic                 rd_vld_r;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_addr];
    end
  end

  // Written-word flags; an unwritten word reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_word = rd_vld_r ? rd_word_r : '0;

endmodule

// File: hdl/bia_word_scan.sv
module bia_word_scan (
  input  logic [bia_pkg::WORD_BITS-1:0] word,
  input  logic [bia_pkg::WIDX_W-1:0]    word_idx,
  input  logic                          wrapped,
  input  logic [bia_pkg::CNT_W-1:0]     start,
  input  logic [bia_pkg::CNT_W-1:0]     count,
  output logic                          found,
  output logic [bia_pkg::BIT_W-1:0]     bit_idx
);
  import bia_pkg::*;

  logic [WORD_BITS-1:0] elig;
  logic [WORD_BITS-1:0] free_bits;

  // Before the wrap: offsets in [start, count); after it: below start
  always_comb begin
    if (wrapped) begin
      elig = below_mask(word_idx, start);
    end else begin
      elig = ~below_mask(word_idx, start) & below_mask(word_idx, count);
    end
    free_bits = elig & ~word;
  end

  // Lowest free eligible bit
  always_comb begin
    bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        bit_idx = BIT_W'(i);
      end
    end
    found = |free_bits;
  end

endmodule

// File: hdl/bitmap_id_allocator_core.sv
// Bitmap element allocator with next-fit search.
// Input channel in_valid/in_ready/in_data carries {op, element}; each
// accepted transfer yields exactly one transfer on out_valid/out_ready/
// out_data carrying {success, granted_element}. The block works on one
// item at a time: in_ready is high only while the sequencer is idle.
// An out-of-range single op or an allocate with zero count goes straight
// to the result; query, occupy and free go through map word read,
// check/update and result. Allocate reads one map word per cycle
// through the word scanner, starting at the next-fit word,
// running to the last word and wrapping to word 0 and back to the start
// word: at most 33 word reads with a full map, fewer when a free element
// turns up early.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes first_element (index 0) or
// element_count (index 1); writes are always taken and must be issued only
// while the block is idle. Reset clears the map (every element free), the
// next-fit pointer and the registers to first_element 0, count 1024.
// When the receiver stalls, the finished result waits in the output
// register and the next result waits in the sequencer until out_ready.
module bitmap_id_allocator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bia_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bia_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bia_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bia_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bia_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [ELEM_W-1:0]    first_r;
  logic [ECOUNT_W-1:0]  ecount_r;
  logic [OFF_W-1:0]     next_slot_r;
  logic [OP_W-1:0]      op_r;
  logic [ELEM_W-1:0]    elem_r;
  logic [OFF_W-1:0]     off_r;
  out_t                 res_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  // Scan issue side
  logic [WIDX_W-1:0]    iw_r;
  logic                 iwrap_r;
  logic                 iss_done_r;
  // Scan evaluate side, in the cycle after the read is issued
  logic                 ev_valid_r;
  logic [WIDX_W-1:0]    ev_word_r;
  logic                 ev_wrap_r;
  logic                 ev_last_r;

  map_req_t             map_req;
  logic [WORD_BITS-1:0] rd_word;
  logic                 scan_found;
  logic [BIT_W-1:0]     scan_bit;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     start;
  logic [CNT_W-1:0]     cnt_m1;
  logic [WIDX_W-1:0]    start_w;
  logic [WIDX_W-1:0]    last_w;
  logic [ELEM_W-1:0]    in_off;
  logic                 in_range;
  logic                 cur_bit;
  logic [OFF_W-1:0]     hit_off;
  logic [CNT_W-1:0]     hit_inc;
  logic                 out_free;
  logic                 iss_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Live count, next-fit start, word bounds, input range check and scan hit offset
  always_comb begin
    if (32'(ecount_r) > 32'(MAX_ELEMENTS)) begin
      cnt = CNT_W'(MAX_ELEMENTS);
    end else begin
      cnt = CNT_W'(ecount_r);
    end
    start   = ({1'b0, next_slot_r} < cnt) ? {1'b0, next_slot_r} : '0;
    cnt_m1  = cnt - 1'b1;
    start_w = start[OFF_W-1:BIT_W];
    last_w  = cnt_m1[OFF_W-1:BIT_W];
    in_off  = in_data.element - first_r;
    in_range = (in_data.element >= first_r) && (32'(in_off) < 32'(cnt));
    cur_bit = rd_word[off_r[BIT_W-1:0]];
    hit_off = {ev_word_r, scan_bit};
    hit_inc = {1'b0, hit_off} + 1'b1;
    iss_last = iwrap_r && (iw_r == start_w);
  end

  // Map memory requests
  always_comb begin
    map_req = '0;
    case (state_r)
      S_READ: begin
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = off_r[OFF_W-1:BIT_W];
      end
      S_CHECK: begin
        map_req.wr_addr = off_r[OFF_W-1:BIT_W];
        if (op_r == OP_OCCUPY && !cur_bit) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_data = rd_word | (WORD_BITS'(1) << off_r[BIT_W-1:0]);
        end else if (op_r == OP_FREE && cur_bit) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_data = rd_word & ~(WORD_BITS'(1) << off_r[BIT_W-1:0]);
        end
      end
      S_SCAN: begin
        map_req.rd_en   = !iss_done_r;
        map_req.rd_addr = iw_r;
        map_req.wr_en   = ev_valid_r && scan_found;
        map_req.wr_addr = ev_word_r;
        map_req.wr_data = rd_word | (WORD_BITS'(1) << scan_bit);
      end
      default: begin
        map_req = '0;
      end
    endcase
  end

  bia_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_word (rd_word)
  );

  bia_word_scan u_scan (
    .word     (rd_word),
    .word_idx (ev_word_r),
    .wrapped  (ev_wrap_r),
    .start    (start),
    .count    (cnt),
    .found    (scan_found),
    .bit_idx  (scan_bit)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_ALLOCATE) begin
            state_nxt = (cnt == '0) ? S_DONE : S_SCAN;
          end else begin
            state_nxt = in_range ? S_READ : S_DONE;
          end
        end
      end
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_DONE;
      S_SCAN: begin
        if (ev_valid_r && (scan_found || ev_last_r)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= FIRST_RESET;
      ecount_r    <= COUNT_RESET;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
      ev_valid_r  <= 1'b0;
      iss_done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIRST_ELEMENT: first_r  <= cfg_data;
          CFG_ELEMENT_COUNT: ecount_r <= cfg_data[ECOUNT_W-1:0];
          default: ;
        endcase
      end

      // Output register
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Scan pipeline control
      if (state_r == S_IDLE) begin
        ev_valid_r <= 1'b0;
        iss_done_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        ev_valid_r <= map_req.rd_en;
        if (!iss_done_r && iss_last) begin
          iss_done_r <= 1'b1;
        end
        if (ev_valid_r && scan_found) begin
          next_slot_r <= (hit_inc >= cnt) ? '0 : hit_inc[OFF_W-1:0];
        end
      end
    end
  end

  // Item payload and scan pointers
  always_ff @(posedge clk) begin
    if (out_free && state_r == S_DONE) begin
      out_data_r <= res_r;
    end
    case (state_r)
      S_IDLE: begin
        op_r    <= in_data.op;
        elem_r  <= in_data.element;
        off_r   <= in_off[OFF_W-1:0];
        iw_r    <= start_w;
        iwrap_r <= 1'b0;
        res_r.success         <= 1'b0;
        res_r.granted_element <= in_data.element;
      end
      S_CHECK: begin
        res_r.granted_element <= elem_r;
        case (op_r)
          OP_QUERY:  res_r.success <= !cur_bit;
          OP_OCCUPY: res_r.success <= !cur_bit;
          OP_FREE:   res_r.success <= cur_bit;
          default:   res_r.success <= 1'b0;
        endcase
      end
      S_SCAN: begin
        ev_word_r <= iw_r;
        ev_wrap_r <= iwrap_r;
        ev_last_r <= iss_last;
        if (!iss_done_r) begin
          if (!iwrap_r && iw_r == last_w) begin
            iwrap_r <= 1'b1;
            iw_r    <= '0;
          end else if (!iss_last) begin
            iw_r <= iw_r + 1'b1;
          end
        end
        if (ev_valid_r && scan_found) begin
          res_r.success         <= 1'b1;
          res_r.granted_element <= first_r + ELEM_W'(hit_off);
        end else begin
          res_r.success         <= 1'b0;
          res_r.granted_element <= elem_r;
        end
      end
      default: ;
    endcase
  end

  // Map writes come only from the check step or a scan hit
  assert property (@(posedge clk) disable iff (!rst_n)
    map_req.wr_en |-> (state_r == S_CHECK) || (ev_valid_r && scan_found))
    else $error("map write outside check or scan hit");

  // A new result appears only after the sequencer finished an item
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result without finished item");

  // The next-fit pointer moves only on a successful allocate
  assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(next_slot_r) |-> $past(state_r) == S_SCAN && $past(scan_found))
    else $error("next-fit pointer moved without allocation");

  // A finished item stays in the done state while the output is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> state_r == S_DONE)
    else $error("result dropped under stall");

endmodule
